// File: rtl/core/pbrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pbrm_pkg;

    // bitmap geometry
    localparam int MAX_PAGES  = 1048576;
    localparam int WORD_BITS  = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int MAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int PG_W       = $clog2(MAX_PAGES + 1);

    // field widths
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 33;
    localparam int START_W = ADDR_W - PAGE_SHIFT;
    localparam int NPG_W   = LEN_W - PAGE_SHIFT + 1;
    localparam int LIMR_W  = 21;
    localparam int FIRST_W = 20;
    localparam int USED_W  = 21;

    // stream and register port widths
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 48;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register indexes
    localparam logic REG_PAGE_TOTAL = 1'b0;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_RANGE    = 2'd1,
        STAT_CONFLICT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_LATCH,
        S_WALK,
        S_WB_NEXT,
        S_WB_DONE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic clear;
        logic rd;
        logic latch;
        logic walk;
        logic wb;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic bad_start;
        logic zero_len;
        logic clear_last;
        logic walk_stop;
        logic walk_last;
        logic word_end;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: rtl/core/page_bitmap_region_marker.sv
// Flow: each accepted request is checked, then every touched word is read, latched,
//   walked one page per cycle and written back before the result is loaded out.
// Throughput: one request at a time; the next item is taken once the result has been loaded for output.
// Reset: synchronous active low; a clearing pass over all 16384 bitmap words then sets
//   every page used, with s_tready low; register writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module page_bitmap_region_marker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [47:0] phys_address, [80:48] length_bytes, [87:81] zero
    input  wire logic [pbrm_pkg::S_DATA_W-1:0]   i_s_tdata,
    // [0] mode
    input  wire logic                            i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [19:0] first_page, [40:20] used_count, [47:41] zero
    output logic      [pbrm_pkg::M_DATA_W-1:0]   o_m_tdata,
    // [1:0] status
    output logic      [1:0]                      o_m_tuser,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pbrm_pkg::APB_AW-1:0]     paddr,
    input  wire logic [pbrm_pkg::APB_DW-1:0]     pwdata,
    output logic      [pbrm_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready
);
    import pbrm_pkg::*;

    t_dp_cmd             cmd;
    t_dp_sts             sts;
    logic                cfg_we;
    logic [LIMR_W-1:0]   page_total;
    t_status             status;
    logic [FIRST_W-1:0]  first;
    logic [USED_W-1:0]   used;

    // register port decode
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_PAGE_TOTAL);
    assign prdata = (paddr[2] == REG_PAGE_TOTAL) ? APB_DW'(page_total) : '0;

    pbrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pbrm_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_s_tuser),
        .i_addr       (i_s_tdata[ADDR_W-1:0]),
        .i_len        (i_s_tdata[ADDR_W +: LEN_W]),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (pwdata[LIMR_W-1:0]),
        .o_page_total (page_total),
        .o_m_valid    (o_m_tvalid),
        .i_m_ready    (i_m_tready),
        .o_status     (status),
        .o_first      (first),
        .o_used       (used)
    );

    // pack the result item
    assign o_m_tuser = status;
    assign o_m_tdata = {(M_DATA_W - FIRST_W - USED_W)'(0), used, first};

endmodule
`default_nettype wire

// File: rtl/core/pbrm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pbrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/pbrm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pbrm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire pbrm_pkg::t_dp_sts i_sts,
    output pbrm_pkg::t_dp_cmd      o_cmd
);
    import pbrm_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.bad_start || i_sts.zero_len) n_state = S_FINISH;
                else n_state = S_READ;
            end
            S_READ:  n_state = S_LATCH;
            S_LATCH: n_state = S_WALK;
            S_WALK: begin
                priority if (i_sts.walk_stop || i_sts.walk_last) n_state = S_WB_DONE;
                else if (i_sts.word_end) n_state = S_WB_NEXT;
                else n_state = S_WALK;
            end
            S_WB_NEXT: n_state = S_READ;
            S_WB_DONE: n_state = S_FINISH;
            S_FINISH: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clear = 1'b1;
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_CHECK:   o_cmd.check = 1'b1;
            S_READ:    o_cmd.rd    = 1'b1;
            S_LATCH:   o_cmd.latch = 1'b1;
            S_WALK:    o_cmd.walk  = 1'b1;
            S_WB_NEXT: o_cmd.wb    = 1'b1;
            S_WB_DONE: o_cmd.wb    = 1'b1;
            S_FINISH:  o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/pbrm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module pbrm_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pbrm_pkg::t_dp_cmd             i_cmd,
    output pbrm_pkg::t_dp_sts                  o_sts,
    input  wire logic                          i_mode,
    input  wire logic [pbrm_pkg::ADDR_W-1:0]   i_addr,
    input  wire logic [pbrm_pkg::LEN_W-1:0]    i_len,
    input  wire logic                          i_cfg_we,
    input  wire logic [pbrm_pkg::LIMR_W-1:0]   i_cfg_data,
    output logic      [pbrm_pkg::LIMR_W-1:0]   o_page_total,
    output logic                               o_m_valid,
    input  wire logic                          i_m_ready,
    output pbrm_pkg::t_status                  o_status,
    output logic      [pbrm_pkg::FIRST_W-1:0]  o_first,
    output logic      [pbrm_pkg::USED_W-1:0]   o_used
);
    import pbrm_pkg::*;

    logic [LIMR_W-1:0]    r_page_total;
    logic [PG_W-1:0]      r_free;
    logic [WIDX_W-1:0]    r_clr_addr;
    logic                 r_mode;
    logic                 r_misal;
    logic [START_W-1:0]   r_start;
    logic [NPG_W-1:0]     r_remain;
    logic [PG_W-1:0]      r_pg;
    logic [WORD_BITS-1:0] r_word;
    logic [WIDX_W-1:0]    r_widx;
    t_status              r_res;
    logic [FIRST_W-1:0]   r_first;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [FIRST_W-1:0]   r_out_first;
    logic [USED_W-1:0]    r_out_used;

    logic [PG_W-1:0]      lim;
    logic [WORD_BITS-1:0] rd_data;
    logic                 cur_bit;
    logic                 range_hit;
    logic [PG_W-1:0]      used_now;
    logic                 ram_we;
    logic [WIDX_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;

    // page limit is the smaller of the register and the bitmap size
    always_comb begin
        if (32'(r_page_total) > 32'(MAX_PAGES)) lim = PG_W'(MAX_PAGES);
        else lim = PG_W'(r_page_total);
    end

    assign used_now  = (lim > r_free) ? (lim - r_free) : '0;
    assign cur_bit   = r_word[r_pg[BIT_W-1:0]];
    assign range_hit = (r_pg >= lim);

    // status toward the controller
    always_comb begin
        o_sts.bad_start  = r_misal || (r_start >= START_W'(lim));
        o_sts.zero_len   = (r_remain == '0);
        o_sts.clear_last = (r_clr_addr == WIDX_W'(MAP_WORDS - 1));
        o_sts.walk_stop  = range_hit || (cur_bit == r_mode);
        o_sts.walk_last  = (r_remain == NPG_W'(1));
        o_sts.word_end   = &r_pg[BIT_W-1:0];
        o_sts.out_free   = !r_out_valid || i_m_ready;
    end

    // bitmap store: clearing pass writes all ones, walk writes back one word
    assign ram_we    = i_cmd.clear || i_cmd.wb;
    assign ram_waddr = i_cmd.clear ? r_clr_addr : r_widx;
    assign ram_wdata = i_cmd.clear ? '1 : r_word;

    pbrm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_pg[BIT_W +: WIDX_W]),
        .o_rdata (rd_data)
    );

    // control state: config, free count, clear sweep, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_total <= LIMR_W'(MAX_PAGES);
            r_free       <= '0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_page_total <= i_cfg_data;
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + WIDX_W'(1);
            if (i_cmd.walk && !o_sts.walk_stop) begin
                if (r_mode) begin
                    if (r_free != '0) r_free <= r_free - PG_W'(1);
                end else begin
                    r_free <= r_free + PG_W'(1);
                end
            end
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_m_ready) r_out_valid <= 1'b0;
        end
    end

    // request and walk payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_misal  <= |i_addr[PAGE_SHIFT-1:0];
            r_start  <= i_addr[ADDR_W-1:PAGE_SHIFT];
            r_pg     <= PG_W'(i_addr[ADDR_W-1:PAGE_SHIFT]);
            r_remain <= NPG_W'(i_len[LEN_W-1:PAGE_SHIFT]) + NPG_W'(|i_len[PAGE_SHIFT-1:0]);
            r_res    <= STAT_OK;
            r_first  <= FIRST_W'(i_addr[ADDR_W-1:PAGE_SHIFT]);
        end
        if (i_cmd.check && o_sts.bad_start) begin
            r_res   <= STAT_RANGE;
            r_first <= '0;
        end
        if (i_cmd.rd) r_widx <= r_pg[BIT_W +: WIDX_W];
        if (i_cmd.latch) r_word <= rd_data;
        if (i_cmd.walk) begin
            priority if (range_hit) begin
                r_res   <= STAT_RANGE;
                r_first <= '0;
            end else if (cur_bit == r_mode) begin
                r_res <= STAT_CONFLICT;
            end else begin
                r_word[r_pg[BIT_W-1:0]] <= r_mode;
                r_pg     <= r_pg + PG_W'(1);
                r_remain <= r_remain - NPG_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res;
            r_out_first  <= r_first;
            r_out_used   <= USED_W'(used_now);
        end
    end

    assign o_page_total = r_page_total;
    assign o_m_valid    = r_out_valid;
    assign o_status     = r_out_status;
    assign o_first      = r_out_first;
    assign o_used       = r_out_used;

endmodule
`default_nettype wire

// File: rtl/core/pbrm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pbrm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [pbrm_pkg::M_DATA_W-1:0] o_m_tdata,
    input wire logic [1:0]                    o_m_tuser
);
    import pbrm_pkg::*;

    // hold a result item until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item dropped or changed while stalled");

    // one request at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while a walk is in flight");

    // range error reports page zero
    a_range_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == STAT_RANGE) |-> (o_m_tdata[FIRST_W-1:0] == '0))
        else $error("range error with nonzero first page");

    // status code and used count stay in range
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser != 2'd3) &&
                       (32'(o_m_tdata[FIRST_W +: USED_W]) <= 32'(MAX_PAGES)))
        else $error("result status or used count out of range");

endmodule

bind page_bitmap_region_marker pbrm_checker u_pbrm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

// File: verif/page_bitmap_region_marker_tb.sv
`timescale 1ns / 1ps
module page_bitmap_region_marker_tb;
    import pbrm_pkg::*;

    localparam int RESET_CYCLES     = 5;
    localparam int NUM_PHASES       = 8;
    localparam int RANDOM_PER_PHASE = 172;
    localparam int WATCHDOG_LIMIT   = 100000;
    localparam int END_DRAIN_CYCLES = 300;
    localparam longint unsigned PAGE_BYTES = 64'd4096;

    // register map: page total at index 0, index 1 has no register
    localparam logic [APB_AW-1:0] PAGE_TOTAL_ADDR = {REG_PAGE_TOTAL, 2'b00};
    localparam logic [APB_AW-1:0] UNMAPPED_ADDR   = 3'd4;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] phys_address;
        logic [LEN_W-1:0]  length_bytes;
    } t_region_req;

    typedef struct packed {
        t_status            status;
        logic [FIRST_W-1:0] first_page;
        logic [USED_W-1:0]  used_count;
    } t_region_result;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // shadow of the bitmap, free-page count and page total register
    bit [WORD_BITS-1:0] page_words [MAP_WORDS];
    int unsigned        free_pages;
    logic [LIMR_W-1:0]  page_total_q;

    t_region_req    region_requests [$];
    t_region_result predicted_marks [$];
    t_region_req    bus_req;

    bit          s_taken;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned idle_cycles;
    int unsigned fail_count;
    int unsigned ok_count;
    int unsigned range_count;
    int unsigned conflict_count;

    page_bitmap_region_marker i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 i_clk = ~i_clk;

    // effective page limit: page total clamped to the bitmap size
    function automatic longint unsigned active_limit();
        longint unsigned lim;
        lim = 64'(page_total_q);
        return (lim > MAX_PAGES) ? MAX_PAGES : lim;
    endfunction

    function automatic logic [ADDR_W-1:0] page_addr(input longint unsigned pg);
        return {pg[ADDR_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};
    endfunction

    // walk the region, flip pages and return the expected result item
    function automatic t_region_result mark_region(input t_region_req rq);
        t_region_result    rs;
        longint unsigned   lim, start, len, npages, pg, i, used;
        bit                want_used;
        logic [WIDX_W-1:0] widx;
        logic [BIT_W-1:0]  bidx;
        rs        = '0;
        rs.status = STAT_OK;
        lim       = active_limit();
        want_used = rq.mode;
        start     = 64'(rq.phys_address >> PAGE_SHIFT);
        len       = 64'(rq.length_bytes);
        if (rq.phys_address[PAGE_SHIFT-1:0] != '0 || start >= lim) begin
            rs.status = STAT_RANGE;
        end else begin
            rs.first_page = start[FIRST_W-1:0];
            npages = (len >> PAGE_SHIFT) + ((len % PAGE_BYTES) != 0 ? 1 : 0);
            for (i = 0; i < npages; i++) begin
                pg = start + i;
                // stop at the limit; pages already flipped stay flipped
                if (pg >= lim) begin
                    rs.status     = STAT_RANGE;
                    rs.first_page = '0;
                    break;
                end
                widx = pg[BIT_W +: WIDX_W];
                bidx = pg[BIT_W-1:0];
                if (page_words[widx][bidx] == want_used) begin
                    rs.status = STAT_CONFLICT;
                    break;
                end
                page_words[widx][bidx] = want_used;
                if (want_used) begin
                    if (free_pages > 0) free_pages--;
                end else begin
                    free_pages++;
                end
            end
        end
        used = (lim > free_pages) ? lim - free_pages : 0;
        rs.used_count = used[USED_W-1:0];
        return rs;
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        if ($urandom_range(0, 15) == 0) return 33'h1_0000_0000;
        return {1'b0, $urandom};
    endfunction

    // mostly well-formed regions near the ends of the map, some noise
    function automatic t_region_req random_request(input longint unsigned lim);
        t_region_req     rq;
        int unsigned     pick, npg;
        longint unsigned start, span, rnd;
        rq.mode = 1'($urandom_range(0, 1));
        pick    = $urandom_range(0, 99);
        rnd     = {$urandom, $urandom};
        if (pick < 6) begin
            rq.phys_address = rnd[ADDR_W-1:0];
            if (rq.phys_address[PAGE_SHIFT-1:0] == '0) rq.phys_address[0] = 1'b1;
            rq.length_bytes = random_length();
        end else if (pick < 12 || lim == 0) begin
            rq.phys_address = {rnd[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            rq.length_bytes = LEN_W'($urandom_range(0, 8 * 4096));
        end else if (pick < 20) begin
            // long region close to the limit: the walk ends within a few pages
            span  = (lim < 16) ? lim : 16;
            start = lim - 1 - $urandom_range(0, span - 1);
            rq.phys_address = page_addr(start);
            rq.length_bytes = random_length();
        end else begin
            span = (lim < 512) ? lim : 512;
            if ($urandom_range(0, 4) == 0) start = lim - span + $urandom_range(0, span - 1);
            else start = $urandom_range(0, span - 1);
            rq.phys_address = page_addr(start);
            case ($urandom_range(0, 19))
                0:       npg = 0;
                1:       npg = $urandom_range(9, 128);
                default: npg = $urandom_range(1, 8);
            endcase
            rq.length_bytes = (npg == 0) ? '0 :
                              LEN_W'(npg * 4096 - $urandom_range(0, 4095));
        end
        return rq;
    endfunction

    task automatic queue_request(input logic mode, input logic [ADDR_W-1:0] addr,
                                 input logic [LEN_W-1:0] len);
        region_requests.push_back('{mode: mode, phys_address: addr, length_bytes: len});
    endtask

    // APB write, then read back when the address holds the page total
    task automatic write_page_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == PAGE_TOTAL_ADDR) page_total_q = value[LIMR_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == PAGE_TOTAL_ADDR) begin
            @(negedge i_clk);
            psel <= 1'b1;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (prdata[LIMR_W-1:0] !== page_total_q) begin
                $error("page total readback: expected %0d, actual %0d",
                       page_total_q, prdata[LIMR_W-1:0]);
                fail_count++;
            end
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // wait until every queued item is taken and every result has come
    task automatic wait_drained();
        @(posedge i_clk);
        while (region_requests.size() != 0 || s_tvalid) @(posedge i_clk);
        @(negedge i_clk);
        while (predicted_marks.size() != 0) @(negedge i_clk);
    endtask

    // drive request items and the result-side ready
    always @(negedge i_clk) begin : request_driver
        t_region_req rq;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!s_tvalid || s_taken) begin
                if (region_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    rq       = region_requests.pop_front();
                    bus_req  = rq;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_DATA_W - LEN_W - ADDR_W){1'b0}},
                                 rq.length_bytes, rq.phys_address};
                    s_tuser  <= rq.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // check result items, predict on each accepted request
    always @(posedge i_clk) begin : result_monitor
        t_region_result head;
        bit             moved;
        s_taken = 1'b0;
        moved   = 1'b0;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (predicted_marks.size() == 0) begin
                    $error("result item with no request pending: status %0d first_page %0d",
                           m_tuser, m_tdata[FIRST_W-1:0]);
                    fail_count++;
                end else begin
                    head = predicted_marks.pop_front();
                    if (m_tuser !== head.status) begin
                        $error("status: expected %0d, actual %0d", head.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[FIRST_W-1:0] !== head.first_page) begin
                        $error("first_page: expected %0d, actual %0d",
                               head.first_page, m_tdata[FIRST_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[FIRST_W +: USED_W] !== head.used_count) begin
                        $error("used_count: expected %0d, actual %0d",
                               head.used_count, m_tdata[FIRST_W +: USED_W]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                moved   = 1'b1;
                s_taken = 1'b1;
                head    = mark_region(bus_req);
                case (head.status)
                    STAT_OK:    ok_count++;
                    STAT_RANGE: range_count++;
                    default:    conflict_count++;
                endcase
                predicted_marks.push_back(head);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int          ph, n;
        int unsigned setting;
        foreach (page_words[w]) page_words[w] = '1;
        free_pages     = 0;
        page_total_q   = LIMR_W'(MAX_PAGES);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        rst_n = 1'b1;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1:       setting = 64;
                2:       setting = 0;
                3:       setting = 1;
                4:       setting = 777;
                5:       setting = 2097151;
                6:       setting = MAX_PAGES;
                default: setting = MAX_PAGES - 1;
            endcase
            if (ph > 0) write_page_reg(PAGE_TOTAL_ADDR, setting);
            // a write to the unused index must leave the limit alone
            if (ph == 1) write_page_reg(UNMAPPED_ADDR, 32'd5);
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            @(posedge i_clk);
            if (ph == 0) begin
                // every page starts used
                queue_request(1'b0, '0, 33'd4096);
                queue_request(1'b0, '0, 33'd1);
                queue_request(1'b1, '0, 33'd8192);
                queue_request(1'b0, page_addr(5), '0);
                queue_request(1'b1, 48'h1001, 33'd4096);
                queue_request(1'b0, 48'hFFFF_FFFF_FFFF, 33'd4096);
                queue_request(1'b1, 48'hFFFF_FFFF_F000, 33'd4096);
                queue_request(1'b0, page_addr(MAX_PAGES - 1), 33'h1_0000_0000);
                queue_request(1'b0, page_addr(MAX_PAGES - 1), 33'd4096);
                queue_request(1'b1, page_addr(MAX_PAGES - 1), 33'd4096);
                queue_request(1'b0, page_addr(62), 33'd16384);
                queue_request(1'b1, page_addr(62), 33'h3001);
                queue_request(1'b0, page_addr(10), 33'd4096);
                queue_request(1'b0, page_addr(9), 33'hFFFF_FFFF);
                queue_request(1'b1, page_addr(9), 33'd8192);
                queue_request(1'b0, page_addr(200), 33'h2001);
                queue_request(1'b1, page_addr(200), 33'h3000);
            end else begin
                if (ph == 1) begin
                    // walk the whole map up to the limit
                    queue_request(1'b0, '0, 33'h1_0000_0000);
                    queue_request(1'b1, page_addr(63), 33'd4096);
                    queue_request(1'b1, page_addr(64), 33'd4096);
                    queue_request(1'b1, '0, 33'd262144);
                end
                for (n = 0; n < RANDOM_PER_PHASE; n++)
                    region_requests.push_back(random_request(active_limit()));
            end
            wait_drained();
        end

        repeat (END_DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d region requests across %0d page-limit settings and four idle patterns",
                 ok_count + range_count + conflict_count, NUM_PHASES);
        $display("Outcomes: %0d ok, %0d range errors, %0d conflicts",
                 ok_count, range_count, conflict_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/pbrm_pkg.sv
rtl/core/pbrm_ram.sv
rtl/core/pbrm_ctrl.sv
rtl/core/pbrm_dpath.sv
rtl/core/page_bitmap_region_marker.sv
rtl/core/pbrm_checker.sv
verif/page_bitmap_region_marker_tb.sv
